// File: hdl/shs_pkg.sv
// Package for the SHA-256 stream hasher: sequencer and pass types, the round
// constants, the initial hash values and the SHA-256 mixing functions.
// Depends on nothing; imported by sha256_stream_hasher.
package shs_pkg;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_LOAD,
    S_ROUND,
    S_UPDATE,
    S_ORD,
    S_OVALID
  } shs_state_e;

  // What a compression pass takes as its sixteen message words.
  typedef enum logic [1:0] {
    PM_FULL,
    PM_PAD_LEN,
    PM_PAD_ONLY,
    PM_LEN_ONLY
  } shs_pmode_e;

  localparam logic ACT_ABSORB = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  localparam logic [7:0]  PadByte   = 8'h80;
  localparam logic [63:0] BlockBits = 64'd512;
  localparam logic [5:0]  PadLimit  = 6'd56;
  localparam logic [5:0]  LastByte  = 6'd63;
  localparam logic [5:0]  LastRound = 6'd63;
  localparam logic [3:0]  LenHiWord = 4'd14;
  localparam logic [3:0]  LenLoWord = 4'd15;
  localparam logic [3:0]  XferLast  = 4'd8;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic logic [31:0] shs_iv(input logic [2:0] idx);
    logic [31:0] r;
    case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      3'd7: r = 32'h5be0cd19;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] shs_k(input logic [5:0] t);
    logic [31:0] r;
    case (t)
      6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;  6'd63: r = 32'hc67178f2;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // Message word j of a pass: from the block memory, the padded partial
  // word, a half of the bit length, or zero.
  function automatic logic [31:0] shs_word_src(input shs_pmode_e  pmode,
                                               input logic [3:0]  j,
                                               input logic [3:0]  fw,
                                               input logic [31:0] pad_word,
                                               input logic [63:0] len,
                                               input logic [31:0] mem_word);
    logic [31:0] r;
    r = 32'h0;
    case (pmode)
      PM_FULL: r = mem_word;
      PM_PAD_LEN, PM_PAD_ONLY: begin
        if (j < fw) begin
          r = mem_word;
        end else if (j == fw) begin
          r = pad_word;
        end else if (pmode == PM_PAD_LEN && j == LenHiWord) begin
          r = len[63:32];
        end else if (pmode == PM_PAD_LEN && j == LenLoWord) begin
          r = len[31:0];
        end
      end
      PM_LEN_ONLY: begin
        if (j == LenHiWord) begin
          r = len[63:32];
        end else if (j == LenLoWord) begin
          r = len[31:0];
        end
      end
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/sha256_stream_hasher.sv
// SHA-256 stream hasher: top level with the hash-word and block memories and
// the compression sequencer. Depends on shs_pkg.
//
// Use: message bytes enter on the slave stream, one byte a beat in tdata with
// tuser low. A beat with tuser high finishes the message; its tdata is ignored.
// The 64th byte of a block starts a compression: the hash words are loaded
// from memory, 64 rounds run at one round a cycle, and the sums are written
// back, all with tready low.
// A finish runs one compression, or two when 56 or more bytes of the block
// are held, padding the block on the fly as words are read. The eight digest
// words then leave on the master stream, word 0 first, tuser carrying the
// word index and tlast marking word 7; each word is read from memory, then offered.
// The block serves one beat at a time: tready is low from a finish beat until
// the last digest word has been taken, and a stalled master holds the word.
// After reset the block writes the eight initial hash values into the hash
// memory, with tready low, and then starts an empty message.
module sha256_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] byte_value
  input  logic        s_axis_tuser_i,   // [0] action: 0 absorb, 1 finish
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser_o,   // [2:0] word_index
  output logic        m_axis_tlast_o    // last_word
);
  import shs_pkg::*;

  // Control state.
  shs_state_e  state_q, state_d;
  shs_pmode_e  pmode_q, pmode_d;
  logic [3:0]  idx_q, idx_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  logic        fin_q, fin_d;

  // Datapath registers: working variables, schedule window, next word and
  // the partial word being assembled from bytes.
  logic [31:0] v_q [8];
  logic [31:0] v_d [8];
  logic [31:0] ws_q [16];
  logic [31:0] ws_d [16];
  logic [31:0] w_q, w_d;
  logic [31:0] acc_q, acc_d;

  // Hash-word memory: 8 words, one read and one write port.
  logic [31:0] hmem [8];
  logic [2:0]  hm_raddr, hm_waddr;
  logic        hm_we;
  logic [31:0] hm_wdata, hm_rdata_q;

  // Block memory: 16 message words, written as each word of bytes completes.
  logic [31:0] bmem [16];
  logic [3:0]  bm_raddr;
  logic        bm_we;
  logic [31:0] bm_wdata, bm_rdata_q;

  logic [39:0] pad_ext;
  logic [31:0] pad_word;
  logic [31:0] t1, t2, ch, maj, w_sched;
  logic [3:0]  next_j;

  always_ff @(posedge clk_i) begin
    if (hm_we) begin
      hmem[hm_waddr] <= hm_wdata;
    end
    hm_rdata_q <= hmem[hm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (bm_we) begin
      bmem[fill_q[5:2]] <= bm_wdata;
    end
    bm_rdata_q <= bmem[bm_raddr];
  end

  // The padded partial word: the bytes already held, then 0x80, then zeros.
  assign pad_ext  = {acc_q, PadByte} << {2'd3 - fill_q[1:0], 3'b000};
  assign pad_word = pad_ext[31:0];

  // One SHA-256 round and the message schedule for the following round.
  assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1  = v_q[7] + big_sigma1(v_q[4]) + ch + shs_k(cnt_q) + w_q;
  assign t2  = big_sigma0(v_q[0]) + maj;
  assign w_sched = small_sigma1(ws_q[15]) + ws_q[10] + small_sigma0(ws_q[2]) + ws_q[1];
  assign next_j  = cnt_q[3:0] + 4'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      pmode_q <= PM_FULL;
      idx_q   <= '0;
      cnt_q   <= '0;
      fill_q  <= '0;
      bits_q  <= '0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pmode_q <= pmode_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      fill_q  <= fill_d;
      bits_q  <= bits_d;
      fin_q   <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    ws_q  <= ws_d;
    w_q   <= w_d;
    acc_q <= acc_d;
  end

  always_comb begin
    state_d  = state_q;
    pmode_d  = pmode_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    fill_d   = fill_q;
    bits_d   = bits_q;
    fin_d    = fin_q;
    v_d      = v_q;
    ws_d     = ws_q;
    w_d      = w_q;
    acc_d    = acc_q;
    hm_raddr = idx_q[2:0];
    hm_we    = 1'b0;
    hm_waddr = idx_q[2:0];
    hm_wdata = shs_iv(idx_q[2:0]);
    bm_raddr = '0;
    bm_we    = 1'b0;
    bm_wdata = {acc_q[23:0], s_axis_tdata_i};
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;

    case (state_q)
      S_INIT: begin
        hm_we = 1'b1;
        if (idx_q[2:0] == 3'd7) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 4'd1;
        end
      end

      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          idx_d = '0;
          if (s_axis_tuser_i == ACT_ABSORB) begin
            acc_d  = {acc_q[23:0], s_axis_tdata_i};
            fill_d = fill_q + 6'd1;
            bm_we  = (fill_q[1:0] == 2'b11);
            if (fill_q == LastByte) begin
              bits_d  = bits_q + BlockBits;
              pmode_d = PM_FULL;
              fin_d   = 1'b0;
              state_d = S_LOAD;
            end
          end else begin
            bits_d  = bits_q + {55'b0, fill_q, 3'b000};
            pmode_d = (fill_q >= PadLimit) ? PM_PAD_ONLY : PM_PAD_LEN;
            fin_d   = 1'b1;
            state_d = S_LOAD;
          end
        end
      end

      S_LOAD: begin
        // Hash words stream in one a cycle; words 0 and 1 of the block are
        // fetched at the end of the load so that round 0 can start at once.
        bm_raddr = {3'b000, idx_q[3]};
        if (idx_q != 4'd0) begin
          for (int i = 0; i < 7; i++) begin
            v_d[i] = v_q[i+1];
          end
          v_d[7] = hm_rdata_q;
        end
        if (idx_q == XferLast) begin
          w_d     = shs_word_src(pmode_q, 4'd0, fill_q[5:2], pad_word, bits_q,
                                 bm_rdata_q);
          cnt_d   = '0;
          idx_d   = '0;
          state_d = S_ROUND;
        end else begin
          idx_d = idx_q + 4'd1;
        end
      end

      S_ROUND: begin
        bm_raddr = cnt_q[3:0] + 4'd2;
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        for (int i = 0; i < 15; i++) begin
          ws_d[i] = ws_q[i+1];
        end
        ws_d[15] = w_q;
        if (cnt_q < 6'd15) begin
          w_d = shs_word_src(pmode_q, next_j, fill_q[5:2], pad_word, bits_q,
                             bm_rdata_q);
        end else begin
          w_d = w_sched;
        end
        if (cnt_q == LastRound) begin
          idx_d   = '0;
          state_d = S_UPDATE;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end

      S_UPDATE: begin
        // Read word k while word k-1 is summed and written back.
        if (idx_q != 4'd0) begin
          hm_we    = 1'b1;
          hm_waddr = 3'(idx_q - 4'd1);
          hm_wdata = hm_rdata_q + v_q[0];
          for (int i = 0; i < 7; i++) begin
            v_d[i] = v_q[i+1];
          end
          v_d[7] = v_q[0];
        end
        if (idx_q == XferLast) begin
          idx_d = '0;
          if (pmode_q == PM_PAD_ONLY) begin
            pmode_d = PM_LEN_ONLY;
            state_d = S_LOAD;
          end else if (fin_q) begin
            state_d = S_ORD;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          idx_d = idx_q + 4'd1;
        end
      end

      S_ORD: begin
        state_d = S_OVALID;
      end

      S_OVALID: begin
        m_axis_tvalid_o = 1'b1;
        if (m_axis_tready_i) begin
          // The word is gone: restore its initial value for the next message.
          hm_we = 1'b1;
          if (idx_q[2:0] == 3'd7) begin
            idx_d   = '0;
            fill_d  = '0;
            bits_d  = '0;
            fin_d   = 1'b0;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + 4'd1;
            state_d = S_ORD;
          end
        end
      end

      default: begin
        idx_d   = '0;
        state_d = S_INIT;
      end
    endcase
  end

  assign m_axis_tdata_o = hm_rdata_q;
  assign m_axis_tuser_o = idx_q[2:0];
  assign m_axis_tlast_o = (idx_q[2:0] == 3'd7);

`ifndef SYNTH
  // Input and output sides are never open together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input and output handshakes open together");

  // A finish beat closes the input until the digest has gone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == ACT_FINISH)
    |=> !s_axis_tready_o)
    else $error("input reopened after finish");

  // The byte that fills a block starts a compression.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == ACT_ABSORB &&
     fill_q == LastByte) |=> (state_q == S_LOAD && fill_q == 6'd0))
    else $error("full block did not start a compression");

  // Handing over the last digest word starts a fresh message.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o)
    |=> (fill_q == 6'd0 && bits_q == 64'd0 && s_axis_tready_o))
    else $error("message state not cleared after digest");

  // The hash words are left alone while the rounds run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND) |-> !hm_we)
    else $error("hash memory written during rounds");
`endif

endmodule
